### sv/color_palette_dac_port_assert.svh
// Assertion macros for the palette DAC port.
// Included by the modules that carry concurrent checks; clocked on clk_i, reset rst_ni.
`ifndef COLOR_PALETTE_DAC_PORT_ASSERT_SVH
`define COLOR_PALETTE_DAC_PORT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that holds on every edge outside reset.
`define CPDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every edge outside reset.
`define CPDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CPDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPDP_ASSERT(lbl, prop, msg)
`define CPDP_ASSERT_IMP(lbl, ante, cons, msg)
`define CPDP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/cpdp_pkg.sv
// Shared types, command codes and an index-wrap helper for the palette DAC port.
// No dependencies; used by cpdp_ctrl, cpdp_dp and the top level.
`timescale 1ns / 1ps
package cpdp_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned ComponentBitsDef  = 6;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned IndexW = 8;
  localparam int unsigned DataW  = 6;

  localparam logic [CmdW-1:0] CMD_SET_WRITE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET_READ   = 2'd1;
  localparam logic [CmdW-1:0] CMD_DATA_WRITE = 2'd2;
  localparam logic [CmdW-1:0] CMD_DATA_READ  = 2'd3;

  localparam logic [1:0] POS_RED  = 2'd0;
  localparam logic [1:0] POS_BLUE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input transaction accepted this cycle
    logic set_idx;   // load index, clear position
    logic set_read;  // mode written by set_idx
    logic mem_wr;
    logic mem_rd;
    logic out_load;  // output register takes a new result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CmdW-1:0] cmd;
  } sts_t;

  // v mod n by restoring subtraction of n<<k, eight narrow steps
  function automatic logic [IndexW-1:0] wrap_index(input logic [IndexW-1:0] v,
                                                   input int unsigned n);
    logic [15:0] r;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(n) << k)) begin
        r = r - (16'(n) << k);
      end
    end
    return r[IndexW-1:0];
  endfunction

endpackage

### sv/cpdp_ctrl.sv
// Handshake controller for the palette DAC port: output-register occupancy FSM.
// Depends on cpdp_pkg and color_palette_dac_port_assert.svh.
`timescale 1ns / 1ps
`include "color_palette_dac_port_assert.svh"
module cpdp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  cpdp_pkg::sts_t sts_i,
  output cpdp_pkg::ctl_t ctl_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic take;

  // a waiting result that is taken this cycle frees the register for the next one
  assign s_tready_o = (state_q == ST_EMPTY) || m_tready_i;
  assign take       = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = (state_q == ST_FULL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (take) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (take) state_d = ST_FULL;
        else if (m_tready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.take     = take;
    ctl_o.out_load = take;
    case (sts_i.cmd)
      cpdp_pkg::CMD_SET_WRITE: begin
        ctl_o.set_idx = take;
      end
      cpdp_pkg::CMD_SET_READ: begin
        ctl_o.set_idx  = take;
        ctl_o.set_read = 1'b1;
      end
      cpdp_pkg::CMD_DATA_WRITE: begin
        ctl_o.mem_wr = take;
      end
      cpdp_pkg::CMD_DATA_READ: begin
        ctl_o.mem_rd = take;
      end
      default: ctl_o = ctl_o;
    endcase
  end

  `CPDP_ASSERT_NXT(a_take_fills, take, state_q == ST_FULL, "accepted item left no result")
  `CPDP_ASSERT_IMP(a_full_blocks, (state_q == ST_FULL) && !m_tready_i, !s_tready_o,
                   "input taken while result is stalled")
  `CPDP_ASSERT_IMP(a_one_access, ctl_o.take, !(ctl_o.mem_wr && ctl_o.mem_rd),
                   "read and write in one transaction")

endmodule

### sv/cpdp_dp.sv
// Datapath of the palette DAC port: palette memory, index/position/mode, result register.
// Depends on cpdp_pkg and color_palette_dac_port_assert.svh.
`timescale 1ns / 1ps
`include "color_palette_dac_port_assert.svh"
module cpdp_dp #(
  parameter int unsigned PALETTE_ENTRIES = cpdp_pkg::PaletteEntriesDef,
  parameter int unsigned COMPONENT_BITS  = cpdp_pkg::ComponentBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cpdp_pkg::CmdW-1:0]    cmd_i,
  input  logic [cpdp_pkg::IndexW-1:0]  index_i,
  input  logic [cpdp_pkg::DataW-1:0]   data_i,
  input  cpdp_pkg::ctl_t               ctl_i,
  output cpdp_pkg::sts_t               sts_o,
  output logic [cpdp_pkg::DataW-1:0]   read_data_o,
  output logic                         read_valid_o
);

  localparam int unsigned MemWords = 3 * PALETTE_ENTRIES;
  localparam int unsigned IdxW     = $clog2(PALETTE_ENTRIES);
  localparam int unsigned AddrW    = $clog2(MemWords);
  localparam int unsigned ExtW     = cpdp_pkg::DataW + 8;

  logic [COMPONENT_BITS-1:0] mem [MemWords];

  logic [IdxW-1:0]            idx_q, idx_d;
  logic [1:0]                 pos_q, pos_d;
  logic                       mode_q, mode_d;
  logic                       rvalid_q;
  logic [COMPONENT_BITS-1:0]  rd_q;
  logic [AddrW-1:0]           addr;
  logic [COMPONENT_BITS-1:0]  wdata;
  logic [7:0]                 data_ext;
  logic [ExtW-1:0]            rd_ext;
  logic [cpdp_pkg::IndexW-1:0] idx_wrap;

  assign sts_o.cmd = cmd_i;

  assign addr = AddrW'({idx_q, 1'b0}) + AddrW'(idx_q) + AddrW'(pos_q);

  assign data_ext = {{(8 - cpdp_pkg::DataW){1'b0}}, data_i};
  assign wdata    = data_ext[COMPONENT_BITS-1:0];
  assign idx_wrap = cpdp_pkg::wrap_index(index_i, PALETTE_ENTRIES);

  always_comb begin
    idx_d  = idx_q;
    pos_d  = pos_q;
    mode_d = mode_q;
    if (ctl_i.set_idx) begin
      idx_d  = idx_wrap[IdxW-1:0];
      pos_d  = cpdp_pkg::POS_RED;
      mode_d = ctl_i.set_read;
    end else if (ctl_i.mem_wr || ctl_i.mem_rd) begin
      // blue done: next entry, wrap at the top
      if (pos_q == cpdp_pkg::POS_BLUE) begin
        pos_d = cpdp_pkg::POS_RED;
        idx_d = (idx_q == IdxW'(PALETTE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      pos_q    <= cpdp_pkg::POS_RED;
      mode_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      mode_q <= mode_d;
      if (ctl_i.out_load) rvalid_q <= ctl_i.mem_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_wr) mem[addr] <= wdata;
    if (ctl_i.mem_rd) rd_q <= mem[addr];
  end

  assign rd_ext       = {{(ExtW - COMPONENT_BITS){1'b0}}, rd_q};
  assign read_data_o  = rvalid_q ? rd_ext[cpdp_pkg::DataW-1:0] : '0;
  assign read_valid_o = rvalid_q;

  `CPDP_ASSERT(a_pos_range, pos_q <= cpdp_pkg::POS_BLUE, "component position out of range")
  `CPDP_ASSERT(a_idx_range, 32'(idx_q) < PALETTE_ENTRIES, "palette index out of range")
  `CPDP_ASSERT_NXT(a_set_clears, ctl_i.set_idx,
                   (pos_q == cpdp_pkg::POS_RED) && (mode_q == $past(ctl_i.set_read)),
                   "index set did not reset position and mode")

endmodule

### sv/color_palette_dac_port.sv
// Top level of the palette DAC port: stream ports, controller and datapath.
// Depends on cpdp_pkg, cpdp_ctrl, cpdp_dp.
//
//  channel   | direction | tdata (low bit up)        | tuser
//  s_axis    | in        | index[7:0], data[13:8]    | command[1:0]
//  m_axis    | out       | read_data[5:0]            | read_valid
//
// One access per cycle: the memory write or registered read and the
// index/position update happen at the edge the input transaction is taken.
// The result is in the output register the cycle after acceptance.
// A stalled result holds input ready low; a result taken in a cycle lets a
// new access in the same cycle. Reset clears index, position, mode and the
// output register; palette contents are not cleared.
`timescale 1ns / 1ps
module color_palette_dac_port #(
  parameter int unsigned PALETTE_ENTRIES = cpdp_pkg::PaletteEntriesDef,
  parameter int unsigned COMPONENT_BITS  = cpdp_pkg::ComponentBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // index[7:0], data[13:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_data[5:0], zero pad
  output logic        m_axis_tuser    // read_valid
);

  cpdp_pkg::ctl_t ctl;
  cpdp_pkg::sts_t sts;
  logic [cpdp_pkg::DataW-1:0] read_data;

  cpdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  cpdp_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COMPONENT_BITS  (COMPONENT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (s_axis_tuser),
    .index_i      (s_axis_tdata[7:0]),
    .data_i       (s_axis_tdata[13:8]),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .read_data_o  (read_data),
    .read_valid_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, read_data};

endmodule
